// ----- hw/rtl/slot_table_allocator_top_assert.svh -----
// Assertion macros shared by the slot table allocator RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef SLOT_TABLE_ALLOCATOR_TOP_ASSERT_SVH
`define SLOT_TABLE_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sta_pkg.sv -----
// Package for the slot table allocator: field widths, command and status codes,
// and the result word type. No dependencies.
package sta_pkg;

  localparam int CMD_W    = 2;
  localparam int CID_W    = 8;
  localparam int SLOT_O_W = 3;
  localparam int STATUS_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWITCH  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic [SLOT_O_W-1:0] slot_index;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

// ----- hw/rtl/sta_if.sv -----
// Valid/ready channel interfaces for the command and result words.
// Depends on sta_pkg for the field widths.
interface sta_in_if import sta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [CID_W-1:0] client_id;
  logic             client_ready;

  modport source (output valid, output cmd, output client_id, output client_ready,
                  input ready);
  modport sink   (input valid, input cmd, input client_id, input client_ready,
                  output ready);
endinterface

interface sta_out_if import sta_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_O_W-1:0] slot_index;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output slot_index, output status, input ready);
  modport sink   (input valid, input slot_index, input status, output ready);
endinterface

// ----- hw/rtl/sta_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/sta_ctrl.sv -----
// Sequencer of the slot table allocator: valid bits, the slot scan counter and
// the shared id comparator. Depends on sta_pkg, sta_if and the assertion header.
`include "slot_table_allocator_top_assert.svh"

module sta_ctrl import sta_pkg::*; #(
  parameter int SLOTS   = 8,
  parameter int ID_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  sta_in_if.sink                   in_ch,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_t                     res,
  output logic                     ram_we,
  output logic [$clog2(SLOTS)-1:0] ram_waddr,
  output logic [ID_BITS-1:0]       ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(SLOTS)-1:0] ram_raddr,
  input  logic [ID_BITS-1:0]       ram_rdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         st_r, st_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic               rdy_r, rdy_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic               step2_r, step2_nxt;
  logic [IW-1:0]      src_r, src_nxt;
  res_t               res_r, res_nxt;

  logic hit;
  logic last;
  logic in_rng;
  logic free;

  // Shared comparator: checks the slot whose id came out of the memory this cycle.
  assign hit  = pend_r && valid_r[cmp_idx_r] && (ram_rdata == id_r);
  assign last = pend_r && (cmp_idx_r == IW'(SLOTS - 1));

  // Free-slot test at the scan counter.
  assign in_rng = (scan_r < SLOTS_C);
  assign free   = in_rng && !valid_r[scan_r[IW-1:0]];

  // Memory ports: reads walk the table during an id search, writes store a placed id.
  assign ram_re    = (st_r == S_FIND) && (rd_idx_r < SLOTS_C);
  assign ram_raddr = rd_idx_r[IW-1:0];
  assign ram_we    = (st_r == S_FREE) && free;
  assign ram_waddr = scan_r[IW-1:0];
  assign ram_wdata = id_r;

  assign in_ch.ready = (st_r == S_IDLE);
  assign res_valid   = (st_r == S_DONE);
  assign res         = res_r;

  // Sequencer.
  always_comb begin
    st_nxt      = st_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    rdy_nxt     = rdy_r;
    valid_nxt   = valid_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    pend_nxt    = pend_r;
    scan_nxt    = scan_r;
    step2_nxt   = step2_r;
    src_nxt     = src_r;
    res_nxt     = res_r;
    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt    = in_ch.cmd;
          id_nxt     = ID_BITS'(in_ch.client_id);
          rdy_nxt    = in_ch.client_ready;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          scan_nxt   = '0;
          step2_nxt  = 1'b0;
          case (in_ch.cmd) inside
            CMD_ALLOC: begin
              st_nxt = S_FREE;
            end
            CMD_RELEASE, CMD_SWITCH: begin
              st_nxt = S_FIND;
            end
            default: begin
              res_nxt = '{slot_index: '0, status: ST_SAME};
              st_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_FIND: begin
        // Keep one read in flight ahead of the comparator.
        pend_nxt = ram_re;
        if (ram_re) begin
          cmp_idx_nxt = rd_idx_r[IW-1:0];
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
        if (hit) begin
          if (cmd_r == CMD_RELEASE) begin
            valid_nxt[cmp_idx_r] = 1'b0;
            res_nxt = '{slot_index: SLOT_O_W'(cmp_idx_r), status: ST_DONE};
            st_nxt  = S_DONE;
          end else if (rdy_r) begin
            res_nxt = '{slot_index: SLOT_O_W'(cmp_idx_r), status: ST_SAME};
            st_nxt  = S_DONE;
          end else begin
            // Look for a free slot on the other team, stepping by two.
            src_nxt   = cmp_idx_r;
            scan_nxt  = {{IW{1'b0}}, ~cmp_idx_r[0]};
            step2_nxt = 1'b1;
            st_nxt    = S_FREE;
          end
        end else if (last) begin
          res_nxt = '{slot_index: '0, status: ST_MISS};
          st_nxt  = S_DONE;
        end
      end
      S_FREE: begin
        if (!in_rng) begin
          if (cmd_r == CMD_ALLOC) begin
            res_nxt = '{slot_index: '0, status: ST_FULL};
          end else begin
            res_nxt = '{slot_index: SLOT_O_W'(src_r), status: ST_SAME};
          end
          st_nxt = S_DONE;
        end else if (free) begin
          valid_nxt[scan_r[IW-1:0]] = 1'b1;
          if (cmd_r == CMD_SWITCH) begin
            valid_nxt[src_r] = 1'b0;
          end
          res_nxt = '{slot_index: SLOT_O_W'(scan_r[IW-1:0]), status: ST_DONE};
          st_nxt  = S_DONE;
        end else begin
          scan_nxt = scan_r + (step2_r ? CW'(2) : CW'(1));
        end
      end
      S_DONE: begin
        if (res_ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      valid_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    id_r      <= id_nxt;
    rdy_r     <= rdy_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    scan_r    <= scan_nxt;
    step2_r   <= step2_nxt;
    src_r     <= src_nxt;
    res_r     <= res_nxt;
  end

  // A waiting result word holds until the output stage takes it.
  `STA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_r), "result changed while stalled")
  // Slot occupancy changes only while a command is being worked.
  `STA_ASSERT_NEXT(a_valid_quiet, st_r == S_IDLE || st_r == S_DONE, $stable(valid_r), "valid bits changed while idle")
  // A team search never crosses to the other parity.
  `STA_ASSERT_NEXT(a_team_parity, st_r == S_FREE && step2_r, st_r != S_FREE || scan_r[0] == $past(scan_r[0]), "switch scan changed parity")
  // A full report means every slot is taken.
  `STA_ASSERT_IMPL(a_full_ok, st_r == S_DONE && res_r.status == ST_FULL, &valid_r, "full reported with a free slot")

endmodule

// ----- hw/rtl/slot_table_allocator_top.sv -----
// Slot table allocator top over sta_pkg, sta_if, sta_ram and sta_ctrl.
// An allocate scans for the lowest free slot; release and switch search the stored ids
// for the id, and a switch then scans the other team for a free slot. Each result word
// leaves through the output register. One command is worked at a time; the scans check one slot a cycle.
// Reset: synchronous; all valid bits clear, stored ids stay undefined.
module slot_table_allocator_top import sta_pkg::*; #(
  parameter int SLOTS   = 8,
  parameter int ID_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  sta_in_if.sink    in_ch,
  sta_out_if.source out_ch
);

  localparam int IW = $clog2(SLOTS);

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ID_BITS-1:0] ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [ID_BITS-1:0] ram_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;
  logic load;

  // Client id store.
  sta_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(SLOTS)
  ) u_ids (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Command sequencer.
  sta_ctrl #(
    .SLOTS  (SLOTS),
    .ID_BITS(ID_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  // Output register: takes a new word when empty or when the current one leaves.
  assign res_ready     = !out_valid_r || out_ch.ready;
  assign load          = res_valid && res_ready;
  assign out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot_index = out_res_r.slot_index;
  assign out_ch.status     = out_res_r.status;

endmodule
